// ===== sv/cstok_pkg.sv =====
// types, constants and scanning helpers for the c subset byte tokenizer
// no dependencies; imported by c_subset_byte_tokenizer
package cstok_pkg;

  localparam int OFFSET_BITS  = 24;
  localparam int COUNTER_BITS = 16;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } byte_word_t;

  typedef struct packed {
    logic [5:0]              token_kind;
    logic [1:0]              error_kind;
    logic [OFFSET_BITS-1:0]  start_offset;
    logic [COUNTER_BITS-1:0] token_length;
    logic [COUNTER_BITS-1:0] line_number;
    logic [COUNTER_BITS-1:0] column_number;
    logic                    last_of_run;
  } token_word_t;

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_IDENT      = 4'd1,
    MODE_NUMBER     = 4'd2,
    MODE_OP         = 4'd3,
    MODE_LINE_CMT   = 4'd4,
    MODE_BLOCK      = 4'd5,
    MODE_BLOCK_STAR = 4'd6,
    MODE_STRING     = 4'd7,
    MODE_CHAR_OPEN  = 4'd8,
    MODE_CHAR_BODY  = 4'd9
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t              mode;
    logic [7:0]              pending_operator;
    logic [47:0]             keyword_prefix;
    logic [OFFSET_BITS-1:0]  token_start;
    logic [COUNTER_BITS-1:0] token_size;
    logic [COUNTER_BITS-1:0] token_line;
    logic [COUNTER_BITS-1:0] token_column;
    logic [OFFSET_BITS-1:0]  byte_offset;
    logic [COUNTER_BITS-1:0] current_line;
    logic [COUNTER_BITS-1:0] current_column;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:             MODE_IDLE,
    pending_operator: 8'd0,
    keyword_prefix:   48'd0,
    token_start:      '0,
    token_size:       '0,
    token_line:       COUNTER_BITS'(1),
    token_column:     COUNTER_BITS'(1),
    byte_offset:      '0,
    current_line:     COUNTER_BITS'(1),
    current_column:   COUNTER_BITS'(1)
  };

  // token kinds
  localparam logic [5:0] TK_IDENT         = 6'd0;
  localparam logic [5:0] TK_NUMBER        = 6'd1;
  localparam logic [5:0] TK_STRING        = 6'd2;
  localparam logic [5:0] TK_CHAR          = 6'd3;
  localparam logic [5:0] TK_INT           = 6'd4;
  localparam logic [5:0] TK_CHAR_KW       = 6'd5;
  localparam logic [5:0] TK_VOID          = 6'd6;
  localparam logic [5:0] TK_IF            = 6'd7;
  localparam logic [5:0] TK_ELSE          = 6'd8;
  localparam logic [5:0] TK_WHILE         = 6'd9;
  localparam logic [5:0] TK_FOR           = 6'd10;
  localparam logic [5:0] TK_RETURN        = 6'd11;
  localparam logic [5:0] TK_CONST         = 6'd12;
  localparam logic [5:0] TK_PLUS          = 6'd13;
  localparam logic [5:0] TK_MINUS         = 6'd14;
  localparam logic [5:0] TK_MULTIPLY      = 6'd15;
  localparam logic [5:0] TK_DIVIDE        = 6'd16;
  localparam logic [5:0] TK_MODULO        = 6'd17;
  localparam logic [5:0] TK_ASSIGN        = 6'd18;
  localparam logic [5:0] TK_EQUAL         = 6'd19;
  localparam logic [5:0] TK_NOT_EQUAL     = 6'd20;
  localparam logic [5:0] TK_LESS          = 6'd21;
  localparam logic [5:0] TK_LESS_EQUAL    = 6'd22;
  localparam logic [5:0] TK_GREATER       = 6'd23;
  localparam logic [5:0] TK_GREATER_EQUAL = 6'd24;
  localparam logic [5:0] TK_LOGICAL_AND   = 6'd25;
  localparam logic [5:0] TK_LOGICAL_OR    = 6'd26;
  localparam logic [5:0] TK_LOGICAL_NOT   = 6'd27;
  localparam logic [5:0] TK_INCREMENT     = 6'd28;
  localparam logic [5:0] TK_DECREMENT     = 6'd29;
  localparam logic [5:0] TK_SEMICOLON     = 6'd30;
  localparam logic [5:0] TK_COMMA         = 6'd31;
  localparam logic [5:0] TK_LEFT_PAREN    = 6'd32;
  localparam logic [5:0] TK_RIGHT_PAREN   = 6'd33;
  localparam logic [5:0] TK_LEFT_BRACE    = 6'd34;
  localparam logic [5:0] TK_RIGHT_BRACE   = 6'd35;
  localparam logic [5:0] TK_LEFT_BRACKET  = 6'd36;
  localparam logic [5:0] TK_RIGHT_BRACKET = 6'd37;
  localparam logic [5:0] TK_EOF           = 6'd39;
  localparam logic [5:0] TK_ERROR         = 6'd40;

  // error kinds
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED  = 2'd1;
  localparam logic [1:0] ERR_OPEN_STRING = 2'd2;
  localparam logic [1:0] ERR_OPEN_CHAR   = 2'd3;

  // keyword spellings, first byte in the low octet
  localparam logic [47:0] KW_INT    = {24'd0, "tni"};
  localparam logic [47:0] KW_CHAR   = {16'd0, "rahc"};
  localparam logic [47:0] KW_VOID   = {16'd0, "diov"};
  localparam logic [47:0] KW_IF     = {32'd0, "fi"};
  localparam logic [47:0] KW_ELSE   = {16'd0, "esle"};
  localparam logic [47:0] KW_WHILE  = {8'd0, "elihw"};
  localparam logic [47:0] KW_FOR    = {24'd0, "rof"};
  localparam logic [47:0] KW_RETURN = "nruter";
  localparam logic [47:0] KW_CONST  = {8'd0, "tsnoc"};

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic [COUNTER_BITS-1:0] sat_count(input logic [COUNTER_BITS-1:0] v);
    return (v == '1) ? v : v + COUNTER_BITS'(1);
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_offset(input logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic scan_state_t consume(input scan_state_t s, input logic [7:0] c);
    scan_state_t r;
    r = s;
    r.token_size  = sat_count(s.token_size);
    r.byte_offset = sat_offset(s.byte_offset);
    if (c == 8'h0a) begin
      r.current_line   = sat_count(s.current_line);
      r.current_column = COUNTER_BITS'(1);
    end else begin
      r.current_column = sat_count(s.current_column);
    end
    return r;
  endfunction

  function automatic scan_state_t begin_token(input scan_state_t s);
    scan_state_t r;
    r = s;
    r.token_start  = s.byte_offset;
    r.token_line   = s.current_line;
    r.token_column = s.current_column;
    r.token_size   = '0;
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [COUNTER_BITS-1:0] size,
                                            input logic [47:0] prefix);
    logic [5:0] k;
    k = TK_IDENT;
    case (size)
      COUNTER_BITS'(2): if (prefix == KW_IF) k = TK_IF;
      COUNTER_BITS'(3): begin
        if (prefix == KW_INT) k = TK_INT;
        else if (prefix == KW_FOR) k = TK_FOR;
      end
      COUNTER_BITS'(4): begin
        if (prefix == KW_CHAR) k = TK_CHAR_KW;
        else if (prefix == KW_VOID) k = TK_VOID;
        else if (prefix == KW_ELSE) k = TK_ELSE;
      end
      COUNTER_BITS'(5): begin
        if (prefix == KW_WHILE) k = TK_WHILE;
        else if (prefix == KW_CONST) k = TK_CONST;
      end
      COUNTER_BITS'(6): if (prefix == KW_RETURN) k = TK_RETURN;
      default: k = TK_IDENT;
    endcase
    return k;
  endfunction

  // pending operator with no partner; lone & and | are errors
  function automatic logic [5:0] single_op_kind(input logic [7:0] p);
    logic [5:0] k;
    case (p)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "/":     k = TK_DIVIDE;
      "!":     k = TK_LOGICAL_NOT;
      "=":     k = TK_ASSIGN;
      "<":     k = TK_LESS;
      ">":     k = TK_GREATER;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // two-character operator, or identifier code when the pair does not combine
  function automatic logic [5:0] pair_op_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = TK_IDENT;
    if (p == "+" && c == "+") k = TK_INCREMENT;
    else if (p == "-" && c == "-") k = TK_DECREMENT;
    else if (p == "&" && c == "&") k = TK_LOGICAL_AND;
    else if (p == "|" && c == "|") k = TK_LOGICAL_OR;
    else if (c == "=") begin
      case (p)
        "!":     k = TK_NOT_EQUAL;
        "=":     k = TK_EQUAL;
        "<":     k = TK_LESS_EQUAL;
        ">":     k = TK_GREATER_EQUAL;
        default: k = TK_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic token_word_t make_word(input scan_state_t s, input logic [5:0] kind,
                                            input logic [1:0] err);
    token_word_t w;
    w.token_kind    = kind;
    w.error_kind    = err;
    w.start_offset  = s.token_start;
    w.token_length  = s.token_size;
    w.line_number   = s.token_line;
    w.column_number = s.token_column;
    w.last_of_run   = 1'b0;
    return w;
  endfunction

endpackage

// ===== sv/c_subset_byte_tokenizer.sv =====
// c subset byte tokenizer: scanner state, per-byte token logic and output queue
// depends on cstok_pkg
//
// Takes one source byte per word and returns tokens with their start offset,
// length, line and column. A byte is taken in every cycle while the output
// queue holds two words or fewer; all scanning for that byte is done in the
// cycle it is taken, and its tokens (none, one or two) land in a four-word
// queue that drives the token side from the next cycle on. One token leaves
// per cycle while token_stall is low, so the two tokens of one byte leave in turn.
// An end word (is_end set, or a zero byte) flushes the pending token, adds an
// eof token and returns the scanner to its reset state.
module c_subset_byte_tokenizer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_stall,
  input  cstok_pkg::byte_word_t    byte_word,
  output logic                     token_valid,
  input  logic                     token_stall,
  output cstok_pkg::token_word_t   token_word
);
  import cstok_pkg::*;

  scan_state_t state;
  scan_state_t state_next;

  token_word_t res [2];
  logic [1:0]  res_count;
  logic [7:0]  c;
  logic        idle_pass;
  logic [5:0]  kind;
  token_word_t eof_word;

  token_word_t queue [4];
  logic [1:0]  head;
  logic [1:0]  tail;
  logic [2:0]  fill;
  logic        take;
  logic        give;

  assign take        = byte_valid && !byte_stall;
  assign give        = token_valid && !token_stall;
  assign byte_stall  = fill > 3'd2;
  assign token_valid = fill != 3'd0;
  assign token_word  = queue[head];
  assign c           = byte_word.char_byte;

  always_comb begin
    state_next = state;
    res[0]     = '0;
    res[1]     = '0;
    res_count  = 2'd0;
    idle_pass  = 1'b0;
    kind       = TK_IDENT;
    eof_word   = '0;

    if (byte_word.is_end || c == 8'd0) begin
      case (state_next.mode)
        MODE_IDENT: begin
          res[0] = make_word(state_next,
                             ident_kind(state_next.token_size, state_next.keyword_prefix),
                             ERR_NONE);
          res_count = 2'd1;
        end
        MODE_NUMBER: begin
          res[0]    = make_word(state_next, TK_NUMBER, ERR_NONE);
          res_count = 2'd1;
        end
        MODE_OP: begin
          kind      = single_op_kind(state_next.pending_operator);
          res[0]    = make_word(state_next, kind,
                                (kind == TK_ERROR) ? ERR_UNEXPECTED : ERR_NONE);
          res_count = 2'd1;
        end
        MODE_STRING: begin
          res[0]    = make_word(state_next, TK_ERROR, ERR_OPEN_STRING);
          res_count = 2'd1;
        end
        MODE_CHAR_OPEN, MODE_CHAR_BODY: begin
          res[0]    = make_word(state_next, TK_ERROR, ERR_OPEN_CHAR);
          res_count = 2'd1;
        end
        default: res_count = 2'd0;
      endcase
      eof_word.token_kind    = TK_EOF;
      eof_word.error_kind    = ERR_NONE;
      eof_word.start_offset  = state_next.byte_offset;
      eof_word.token_length  = '0;
      eof_word.line_number   = state_next.current_line;
      eof_word.column_number = state_next.current_column;
      res[res_count[0]]      = eof_word;
      res_count              = res_count + 2'd1;
      state_next             = SCAN_RESET;
    end else begin
      case (state_next.mode)
        MODE_IDLE: idle_pass = 1'b1;
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (state_next.token_size < COUNTER_BITS'(6))
              state_next.keyword_prefix = state_next.keyword_prefix |
                  (48'(c) << {state_next.token_size[2:0], 3'b000});
            state_next = consume(state_next, c);
          end else begin
            res[0] = make_word(state_next,
                               ident_kind(state_next.token_size, state_next.keyword_prefix),
                               ERR_NONE);
            res_count       = 2'd1;
            state_next.mode = MODE_IDLE;
            idle_pass       = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            state_next = consume(state_next, c);
          end else begin
            res[0]          = make_word(state_next, TK_NUMBER, ERR_NONE);
            res_count       = 2'd1;
            state_next.mode = MODE_IDLE;
            idle_pass       = 1'b1;
          end
        end
        MODE_OP: begin
          kind = pair_op_kind(state_next.pending_operator, c);
          if (state_next.pending_operator == "/" && c == "/") begin
            state_next      = consume(state_next, c);
            state_next.mode = MODE_LINE_CMT;
          end else if (state_next.pending_operator == "/" && c == "*") begin
            state_next      = consume(state_next, c);
            state_next.mode = MODE_BLOCK;
          end else if (kind != TK_IDENT) begin
            state_next      = consume(state_next, c);
            res[0]          = make_word(state_next, kind, ERR_NONE);
            res_count       = 2'd1;
            state_next.mode = MODE_IDLE;
          end else begin
            kind            = single_op_kind(state_next.pending_operator);
            res[0]          = make_word(state_next, kind,
                                        (kind == TK_ERROR) ? ERR_UNEXPECTED : ERR_NONE);
            res_count       = 2'd1;
            state_next.mode = MODE_IDLE;
            idle_pass       = 1'b1;
          end
        end
        MODE_LINE_CMT: begin
          if (c == 8'h0a) state_next.mode = MODE_IDLE;
          state_next = consume(state_next, c);
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          if (c == "*") state_next.mode = MODE_BLOCK_STAR;
          else if (c == "/" && state_next.mode == MODE_BLOCK_STAR) state_next.mode = MODE_IDLE;
          else state_next.mode = MODE_BLOCK;
          state_next = consume(state_next, c);
        end
        MODE_STRING: begin
          state_next = consume(state_next, c);
          if (c == "\"") begin
            res[0]          = make_word(state_next, TK_STRING, ERR_NONE);
            res_count       = 2'd1;
            state_next.mode = MODE_IDLE;
          end
        end
        MODE_CHAR_OPEN: begin
          state_next      = consume(state_next, c);
          state_next.mode = MODE_CHAR_BODY;
        end
        MODE_CHAR_BODY: begin
          if (c == "'") begin
            state_next = consume(state_next, c);
            res[0]     = make_word(state_next, TK_CHAR, ERR_NONE);
          end else begin
            res[0]    = make_word(state_next, TK_ERROR, ERR_OPEN_CHAR);
            idle_pass = 1'b1;
          end
          res_count       = 2'd1;
          state_next.mode = MODE_IDLE;
        end
        default: begin
          state_next.mode = MODE_IDLE;
          idle_pass       = 1'b1;
        end
      endcase

      // fresh scan of the byte between tokens
      if (idle_pass) begin
        if (c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a) begin
          state_next = consume(state_next, c);
        end else begin
          state_next = begin_token(state_next);
          state_next = consume(state_next, c);
          if (is_alpha(c) || c == "_") begin
            state_next.mode           = MODE_IDENT;
            state_next.keyword_prefix = 48'(c);
          end else if (is_digit(c)) begin
            state_next.mode = MODE_NUMBER;
          end else if (c inside {"+", "-", "!", "=", "<", ">", "&", "|", "/"}) begin
            state_next.mode             = MODE_OP;
            state_next.pending_operator = c;
          end else if (c == "\"") begin
            state_next.mode = MODE_STRING;
          end else if (c == "'") begin
            state_next.mode = MODE_CHAR_OPEN;
          end else begin
            case (c)
              "(":     kind = TK_LEFT_PAREN;
              ")":     kind = TK_RIGHT_PAREN;
              "{":     kind = TK_LEFT_BRACE;
              "}":     kind = TK_RIGHT_BRACE;
              "[":     kind = TK_LEFT_BRACKET;
              "]":     kind = TK_RIGHT_BRACKET;
              ";":     kind = TK_SEMICOLON;
              ",":     kind = TK_COMMA;
              "*":     kind = TK_MULTIPLY;
              "%":     kind = TK_MODULO;
              default: kind = TK_ERROR;
            endcase
            res[res_count[0]] = make_word(state_next, kind,
                                          (kind == TK_ERROR) ? ERR_UNEXPECTED : ERR_NONE);
            res_count         = res_count + 2'd1;
            state_next.mode   = MODE_IDLE;
          end
        end
      end
    end

    // mark the final token of this byte
    if (res_count == 2'd1) res[0].last_of_run = 1'b1;
    if (res_count == 2'd2) res[1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_RESET;
    end else if (take) begin
      state <= state_next;
    end
  end

  // output queue: up to two words in per taken byte, one word out per cycle while token_stall is low
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 2'd0;
      tail <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (give) head <= head + 2'd1;
      if (take) tail <= tail + res_count;
      fill <= fill + (take ? {1'b0, res_count} : 3'd0) - (give ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_count != 2'd0) queue[tail] <= res[0];
    if (take && res_count == 2'd2) queue[tail + 2'd1] <= res[1];
  end

endmodule
